### sv/genotype_site_summary_unit_macros.svh
// Assertion helpers for the top module, which checks its own logic.
`ifndef GENOTYPE_SITE_SUMMARY_UNIT_MACROS_SVH
`define GENOTYPE_SITE_SUMMARY_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define GSU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define GSU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/gsu_pkg.sv
package gsu_pkg;

    localparam int ALLELE_W    = 11;
    localparam int COUNT_W     = 16;
    localparam int TOTAL_W     = 17;
    localparam int SUM_W       = 19;
    localparam int FRAC_BITS   = 16;
    localparam int FRAC_W      = FRAC_BITS + 1;
    localparam int NUM_CLASSES = 7;
    localparam int DIV_STEPS   = FRAC_BITS + 1;
    localparam int STEP_W      = $clog2(DIV_STEPS + 1);

    // Class counter slots, in result order.
    localparam int CLS_REF_PASS = 0;
    localparam int CLS_HET_PASS = 1;
    localparam int CLS_HOM_PASS = 2;
    localparam int CLS_REF_FAIL = 3;
    localparam int CLS_HET_FAIL = 4;
    localparam int CLS_HOM_FAIL = 5;
    localparam int CLS_MISSING  = 6;

    typedef logic signed [ALLELE_W-1:0] t_allele;
    typedef logic [COUNT_W-1:0]         t_count;
    typedef logic [TOTAL_W-1:0]         t_total;
    typedef logic [SUM_W-1:0]           t_sum;
    typedef logic [FRAC_W-1:0]          t_frac;

    typedef struct packed {
        logic [NUM_CLASSES-1:0][COUNT_W-1:0] counts;
        t_total                              ref_total;
        t_total                              alt_total;
        t_total                              other_total;
    } t_tally;

    typedef struct packed {
        logic start;
        t_total num;
        t_sum   den;
    } t_div_req;

    typedef struct packed {
        logic  done;
        t_frac quo;
    } t_div_rsp;

endpackage

### sv/gsu_if.sv
interface gsu_sample_if;
    logic            valid;
    logic            ready;
    gsu_pkg::t_allele allele_first;
    gsu_pkg::t_allele allele_second;
    logic            passed_filter;
    logic            last_sample;

    modport source (
        output valid, allele_first, allele_second, passed_filter, last_sample,
        input  ready
    );
    modport sink (
        input  valid, allele_first, allele_second, passed_filter, last_sample,
        output ready
    );
endinterface

interface gsu_site_if;
    logic           valid;
    logic           ready;
    gsu_pkg::t_count ref_pass_count;
    gsu_pkg::t_count het_pass_count;
    gsu_pkg::t_count hom_pass_count;
    gsu_pkg::t_count ref_fail_count;
    gsu_pkg::t_count het_fail_count;
    gsu_pkg::t_count hom_fail_count;
    gsu_pkg::t_count missing_count;
    gsu_pkg::t_frac  alt_fraction;
    logic           monomorphic;

    modport source (
        output valid, ref_pass_count, het_pass_count, hom_pass_count,
               ref_fail_count, het_fail_count, hom_fail_count, missing_count,
               alt_fraction, monomorphic,
        input  ready
    );
    modport sink (
        input  valid, ref_pass_count, het_pass_count, hom_pass_count,
               ref_fail_count, het_fail_count, hom_fail_count, missing_count,
               alt_fraction, monomorphic,
        output ready
    );
endinterface

### sv/gsu_tally.sv
module gsu_tally #(
    parameter int ALLELE_LIMIT = 256
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_clr,
    input  gsu_pkg::t_allele i_allele_first,
    input  gsu_pkg::t_allele i_allele_second,
    input  logic             i_passed_filter,
    output gsu_pkg::t_tally  o_tally
);
    import gsu_pkg::*;

    localparam t_count     COUNT_MAX = '1;
    localparam t_total     TOTAL_MAX = '1;
    localparam int         IDX_W     = ALLELE_W - 1;

    function automatic t_total sat_add(t_total t, logic [1:0] inc);
        logic [TOTAL_W:0] s;
        s = {1'b0, t} + {{(TOTAL_W-1){1'b0}}, inc};
        return (s > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : s[TOTAL_W-1:0];
    endfunction

    t_tally r_tally;
    t_tally n_tally;

    logic v1, v2, z1, z2, o1, o2;
    logic [1:0] inc_ref, inc_alt, inc_other;
    logic [NUM_CLASSES-1:0] hit;

    always_comb begin
        v1 = !i_allele_first[ALLELE_W-1] &&
             ({1'b0, i_allele_first[IDX_W-1:0]} < ALLELE_W'(ALLELE_LIMIT));
        v2 = !i_allele_second[ALLELE_W-1] &&
             ({1'b0, i_allele_second[IDX_W-1:0]} < ALLELE_W'(ALLELE_LIMIT));
        z1 = v1 && (i_allele_first  == '0);
        z2 = v2 && (i_allele_second == '0);
        o1 = v1 && (i_allele_first  == ALLELE_W'(1));
        o2 = v2 && (i_allele_second == ALLELE_W'(1));
        inc_ref   = {1'b0, z1} + {1'b0, z2};
        inc_alt   = {1'b0, o1} + {1'b0, o2};
        inc_other = {1'b0, v1 && !z1 && !o1} + {1'b0, v2 && !z2 && !o2};

        hit = '0;
        if (z1 && z2) begin
            if (i_passed_filter) begin
                hit[CLS_REF_PASS] = 1'b1;
            end else begin
                hit[CLS_REF_FAIL] = 1'b1;
            end
        end else if (v1 && v2 && (i_allele_first != i_allele_second)) begin
            if (i_passed_filter) begin
                hit[CLS_HET_PASS] = 1'b1;
            end else begin
                hit[CLS_HET_FAIL] = 1'b1;
            end
        end else if (v1 && v2) begin
            if (i_passed_filter) begin
                hit[CLS_HOM_PASS] = 1'b1;
            end else begin
                hit[CLS_HOM_FAIL] = 1'b1;
            end
        end else begin
            hit[CLS_MISSING] = 1'b1;
        end

        n_tally = r_tally;
        if (i_clr) begin
            n_tally = '0;
        end else if (i_en) begin
            for (int k = 0; k < NUM_CLASSES; k++) begin
                if (hit[k] && (r_tally.counts[k] != COUNT_MAX)) begin
                    n_tally.counts[k] = r_tally.counts[k] + COUNT_W'(1);
                end
            end
            n_tally.ref_total   = sat_add(r_tally.ref_total, inc_ref);
            n_tally.alt_total   = sat_add(r_tally.alt_total, inc_alt);
            n_tally.other_total = sat_add(r_tally.other_total, inc_other);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tally <= '0;
        end else begin
            r_tally <= n_tally;
        end
    end

    assign o_tally = r_tally;

endmodule

### sv/gsu_div.sv
module gsu_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gsu_pkg::t_div_req i_req,
    output gsu_pkg::t_div_rsp o_rsp
);
    import gsu_pkg::*;

    localparam int REM_W = SUM_W + 1;

    logic [REM_W-1:0]  r_rem, n_rem;
    t_sum              r_den, n_den;
    t_frac             r_quo, n_quo;
    logic [STEP_W-1:0] r_cnt, n_cnt;
    logic              r_busy, n_busy;
    logic              r_done, n_done;

    logic              fits;
    logic [REM_W-1:0]  rem_kept;

    // One compare and subtract per cycle, one quotient bit per step.
    always_comb begin
        fits     = r_rem >= {1'b0, r_den};
        rem_kept = fits ? (r_rem - {1'b0, r_den}) : r_rem;

        n_rem  = r_rem;
        n_den  = r_den;
        n_quo  = r_quo;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;

        if (i_req.start) begin
            n_rem  = REM_W'(i_req.num);
            n_den  = i_req.den;
            n_quo  = '0;
            n_cnt  = STEP_W'(DIV_STEPS);
            // Zero divisor: no alleles seen, fraction stays zero.
            n_busy = (i_req.den != '0);
            n_done = (i_req.den == '0);
        end else if (r_busy) begin
            n_rem = {rem_kept[REM_W-2:0], 1'b0};
            n_quo = {r_quo[FRAC_W-2:0], fits};
            n_cnt = r_cnt - STEP_W'(1);
            if (r_cnt == STEP_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_den <= n_den;
        r_quo <= n_quo;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

### sv/genotype_site_summary_unit.sv
// Per-site genotype summary.
// Sample channel (i_sample): one genotype per transaction, two allele
// indices (-1 missing), a pass flag and a last-sample flag closing the site.
// Site channel (o_site): one transaction per site with seven class counts,
// the allele-1 fraction in unsigned Q1.16 (floor) and a monomorphic flag.
// Throughput: samples that are not the last of their site stream back to
// back. The last sample starts the closing sequence: a sum state that hands
// the summed allele totals to a restoring divider, which shares one
// compare/subtract unit and yields one quotient bit a cycle (17 steps).
// The sample channel is not ready during this; the divide steps are skipped
// when no valid allele was seen, and the channel is ready again in the same
// cycle that the site result turns valid.
// The result sits in an output register, so samples of the next site are
// taken while it waits; a stalled receiver only holds the next site close.
// Reset (synchronous, active low) clears all counters and drops o_site.valid.
`include "genotype_site_summary_unit_macros.svh"

module genotype_site_summary_unit #(
    parameter int ALLELE_LIMIT = 256
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    gsu_sample_if.sink  i_sample,
    gsu_site_if.source  o_site
);
    import gsu_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SUM  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_LOAD = 2'd3;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;

    t_tally   tally;
    t_div_req div_req;
    t_div_rsp div_rsp;

    logic accept;
    logic load;

    t_count r_counts [NUM_CLASSES];
    t_frac  r_frac;
    logic   r_mono;

    assign accept = i_sample.valid && i_sample.ready;
    assign i_sample.ready = (r_state == S_IDLE);
    assign load = (r_state == S_LOAD) && (!r_out_valid || o_site.ready);

    gsu_tally #(
        .ALLELE_LIMIT (ALLELE_LIMIT)
    ) u_tally (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (accept),
        .i_clr           (load),
        .i_allele_first  (i_sample.allele_first),
        .i_allele_second (i_sample.allele_second),
        .i_passed_filter (i_sample.passed_filter),
        .o_tally         (tally)
    );

    always_comb begin
        div_req.start = (r_state == S_SUM);
        div_req.num   = tally.alt_total;
        div_req.den   = SUM_W'(tally.ref_total) + SUM_W'(tally.alt_total)
                      + SUM_W'(tally.other_total);
    end

    gsu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_sample.last_sample) begin
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                if (load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_out_valid = r_out_valid;
        if (load) begin
            n_out_valid = 1'b1;
        end else if (o_site.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Capture the closed site; the tally clears on the same edge.
    always_ff @(posedge i_clk) begin
        if (load) begin
            for (int k = 0; k < NUM_CLASSES; k++) begin
                r_counts[k] <= tally.counts[k];
            end
            r_frac <= div_rsp.quo;
            r_mono <= (tally.ref_total == '0) && (tally.alt_total != '0)
                      && (tally.other_total == '0);
        end
    end

    assign o_site.valid          = r_out_valid;
    assign o_site.ref_pass_count = r_counts[CLS_REF_PASS];
    assign o_site.het_pass_count = r_counts[CLS_HET_PASS];
    assign o_site.hom_pass_count = r_counts[CLS_HOM_PASS];
    assign o_site.ref_fail_count = r_counts[CLS_REF_FAIL];
    assign o_site.het_fail_count = r_counts[CLS_HET_FAIL];
    assign o_site.hom_fail_count = r_counts[CLS_HOM_FAIL];
    assign o_site.missing_count  = r_counts[CLS_MISSING];
    assign o_site.alt_fraction   = r_frac;
    assign o_site.monomorphic    = r_mono;

    `GSU_ASSERT_NEXT(a_last_starts_close, i_clk, i_rst_n, accept && i_sample.last_sample, r_state == S_SUM && !i_sample.ready, "last sample did not start the site close")
    `GSU_ASSERT_NOW(a_quo_in_range, i_clk, i_rst_n, div_rsp.done, div_rsp.quo <= FRAC_W'(1 << FRAC_BITS), "fraction above one")
    `GSU_ASSERT_NEXT(a_load_shows_result, i_clk, i_rst_n, load, o_site.valid && r_state == S_IDLE && tally.ref_total == '0 && tally.alt_total == '0, "site close did not present result and clear tally")
    `GSU_ASSERT_NOW(a_mono_is_whole, i_clk, i_rst_n, o_site.valid && o_site.monomorphic, o_site.alt_fraction == FRAC_W'(1 << FRAC_BITS), "monomorphic site without full allele-1 fraction")

endmodule
